// ===== rtl/core/cowt_pkg.sv =====
// Shared types and fixed-point constants for the camera object to world transform.
`timescale 1ns / 1ps
`default_nettype none

package cowt_pkg;

   localparam int PosW  = 32;
   localparam int QuatW = 16;
   localparam int QprodW = 32;
   localparam int EntW  = 34;
   localparam int MatShift = 12;
   localparam int MatW  = EntW - MatShift;
   localparam int BodyW = 33;
   localparam int ProdW = MatW + BodyW;
   localparam int AccW  = ProdW + 2;
   localparam int RowShift = 16;
   localparam int RowW  = AccW - RowShift;
   localparam int SumW  = RowW + 2;

   localparam int CsrIndexW = 2;
   localparam logic [CsrIndexW-1:0] CSR_OFFSET_X = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_OFFSET_Y = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_OFFSET_Z = 2'd2;

   typedef logic signed [PosW-1:0]  pos_type;
   typedef logic signed [QuatW-1:0] quat_type;

   typedef struct packed {
      pos_type x;
      pos_type y;
      pos_type z;
   } vec_type;

   typedef struct packed {
      pos_type  cam_pos_x;
      pos_type  cam_pos_y;
      pos_type  cam_pos_z;
      quat_type quat_w;
      quat_type quat_x;
      quat_type quat_y;
      quat_type quat_z;
      pos_type  obj_cam_x;
      pos_type  obj_cam_y;
      pos_type  obj_cam_z;
   } req_type;

   typedef struct packed {
      pos_type world_x;
      pos_type world_y;
      pos_type world_z;
   } rsp_type;

   localparam vec_type OFFSET_RESET = '{x: 32'sd6554, y: 32'sd13107, z: 32'sd13107};

   localparam logic signed [EntW-1:0] EntOne  = 34'sd268435456;
   localparam logic signed [EntW-1:0] EntHalf = 34'sd2048;
   localparam logic signed [AccW-1:0] AccHalf = 57'sd32768;

endpackage

`default_nettype wire

// ===== rtl/core/cowt_stream_if.sv =====
// Valid/ready channel interface carrying one word of a given payload type.
`timescale 1ns / 1ps
`default_nettype none

interface cowt_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cowt_front.sv =====
// Front end: accepts request words and substitutes the held object position on no detection.
`timescale 1ns / 1ps
`default_nettype none

module cowt_front (
   input  logic               clock,
   input  logic               reset,
   cowt_stream_if.sink        req_ch,
   input  logic               queue_full,
   output logic               push_valid,
   output cowt_pkg::req_type  push_data
);
   import cowt_pkg::*;

   vec_type held_ff;
   vec_type held_in;
   vec_type used;
   logic    no_detect;

   assign req_ch.ready = !queue_full;
   assign push_valid   = req_ch.valid && !queue_full;
   assign no_detect    = (req_ch.data.obj_cam_z == '0);

   always_comb begin
      if (no_detect) begin
         used = held_ff;
      end else begin
         used = '{x: req_ch.data.obj_cam_x, y: req_ch.data.obj_cam_y, z: req_ch.data.obj_cam_z};
      end
      push_data           = req_ch.data;
      push_data.obj_cam_x = used.x;
      push_data.obj_cam_y = used.y;
      push_data.obj_cam_z = used.z;
      held_in = held_ff;
      if (push_valid && (used.z != '0)) begin
         held_in = used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cowt_queue.sv =====
// Small FIFO that decouples the front end from the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module cowt_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cowt_pkg::req_type push_data,
   output logic              full,
   input  logic              pop,
   output cowt_pkg::req_type pop_data,
   output logic              empty
);
   import cowt_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   req_type             mem_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff;
   logic [PtrW-1:0]     wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff;
   logic [PtrW-1:0]     rd_ptr_in;
   logic [CntW-1:0]     count_ff;
   logic [CntW-1:0]     count_in;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(DEPTH))
      else $error("Queue fill count exceeds its depth.");
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("Word pushed into a full queue.");
   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("Queue fill count did not drop after a pop.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cowt_back.sv =====
// Back end: sequences rotation matrix and transform products through one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module cowt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  cowt_pkg::req_type  item_data,
   output logic               item_ready,
   input  cowt_pkg::vec_type  offsets,
   cowt_stream_if.source      rsp_ch
);
   import cowt_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_QMUL = 3'd1;
   localparam logic [2:0] ST_RMAT = 3'd2;
   localparam logic [2:0] ST_VMUL = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam logic [3:0] QP_XX = 4'd0;
   localparam logic [3:0] QP_YY = 4'd1;
   localparam logic [3:0] QP_ZZ = 4'd2;
   localparam logic [3:0] QP_XY = 4'd3;
   localparam logic [3:0] QP_XZ = 4'd4;
   localparam logic [3:0] QP_YZ = 4'd5;
   localparam logic [3:0] QP_WX = 4'd6;
   localparam logic [3:0] QP_WY = 4'd7;
   localparam logic [3:0] QP_WZ = 4'd8;

   localparam logic [3:0] M00 = 4'd0;
   localparam logic [3:0] M01 = 4'd1;
   localparam logic [3:0] M02 = 4'd2;
   localparam logic [3:0] M10 = 4'd3;
   localparam logic [3:0] M11 = 4'd4;
   localparam logic [3:0] M12 = 4'd5;
   localparam logic [3:0] M20 = 4'd6;
   localparam logic [3:0] M21 = 4'd7;
   localparam logic [3:0] M22 = 4'd8;
   localparam logic [3:0] NumEnt = 4'd9;

   localparam logic [1:0] BODY_FWD  = 2'd0;
   localparam logic [1:0] BODY_LEFT = 2'd1;
   localparam logic [1:0] BODY_UP   = 2'd2;
   localparam logic [1:0] ROW_LAST  = 2'd2;

   localparam pos_type PosMax = 32'sh7fffffff;
   localparam pos_type PosMin = 32'sh80000000;

   logic [2:0]                 state_ff, state_in;
   logic [3:0]                 cnt_ff, cnt_in;
   logic [1:0]                 row_ff, row_in;
   logic [1:0]                 col_ff, col_in;
   logic                       pv_ff, pv_in;
   logic [1:0]                 prow_ff, prow_in;
   logic [1:0]                 pcol_ff, pcol_in;
   req_type                    item_ff, item_in;
   logic signed [QprodW-1:0]   qp_ff [9];
   logic signed [QprodW-1:0]   qp_in [9];
   logic signed [MatW-1:0]     rm_ff [9];
   logic signed [MatW-1:0]     rm_in [9];
   logic signed [ProdW-1:0]    prod_ff, prod_in;
   logic signed [AccW-1:0]     acc_ff, acc_in;
   logic signed [RowW-1:0]     rs_ff [3];
   logic signed [RowW-1:0]     rs_in [3];
   logic                       out_valid_ff, out_valid_in;
   rsp_type                    out_data_ff, out_data_in;

   logic signed [MatW-1:0]     mul_a;
   logic signed [BodyW-1:0]    mul_b;
   logic signed [ProdW-1:0]    mul_p;
   logic signed [BodyW-1:0]    body;
   logic signed [AccW-1:0]     acc_sum;
   logic signed [AccW-1:0]     round_sum;
   rsp_type                    world;

   function automatic logic signed [MatW-1:0] mat_entry(
      input logic                     diag,
      input logic                     minus,
      input logic signed [QprodW-1:0] a,
      input logic signed [QprodW-1:0] b
   );
      logic signed [EntW-1:0] s;
      logic signed [EntW-1:0] e;
      s = minus ? (EntW'(a) - EntW'(b)) : (EntW'(a) + EntW'(b));
      e = diag ? (EntOne - (s <<< 1)) : (s <<< 1);
      e = e + EntHalf;
      return e[EntW-1:MatShift];
   endfunction

   function automatic pos_type sat_pos(input logic signed [SumW-1:0] v);
      logic [SumW-PosW:0] hi;
      hi = v[SumW-1:PosW-1];
      if ((hi == '0) || (hi == '1)) begin
         return v[PosW-1:0];
      end else if (v[SumW-1]) begin
         return PosMin;
      end else begin
         return PosMax;
      end
   endfunction

   always_comb begin
      case (col_ff)
         BODY_FWD:  body = BodyW'(item_ff.obj_cam_z);
         BODY_LEFT: body = -BodyW'(item_ff.obj_cam_x);
         BODY_UP:   body = -BodyW'(item_ff.obj_cam_y);
         default:   body = '0;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_QMUL) begin
         unique case (cnt_ff)
            QP_XX: begin mul_a = MatW'(item_ff.quat_x); mul_b = BodyW'(item_ff.quat_x); end
            QP_YY: begin mul_a = MatW'(item_ff.quat_y); mul_b = BodyW'(item_ff.quat_y); end
            QP_ZZ: begin mul_a = MatW'(item_ff.quat_z); mul_b = BodyW'(item_ff.quat_z); end
            QP_XY: begin mul_a = MatW'(item_ff.quat_x); mul_b = BodyW'(item_ff.quat_y); end
            QP_XZ: begin mul_a = MatW'(item_ff.quat_x); mul_b = BodyW'(item_ff.quat_z); end
            QP_YZ: begin mul_a = MatW'(item_ff.quat_y); mul_b = BodyW'(item_ff.quat_z); end
            QP_WX: begin mul_a = MatW'(item_ff.quat_w); mul_b = BodyW'(item_ff.quat_x); end
            QP_WY: begin mul_a = MatW'(item_ff.quat_w); mul_b = BodyW'(item_ff.quat_y); end
            QP_WZ: begin mul_a = MatW'(item_ff.quat_w); mul_b = BodyW'(item_ff.quat_z); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else if (cnt_ff < NumEnt) begin
         mul_a = rm_ff[cnt_ff];
         mul_b = body;
      end
   end

   assign mul_p = mul_a * mul_b;

   assign acc_sum   = ((pcol_ff == BODY_FWD) ? '0 : acc_ff) + AccW'(prod_ff);
   assign round_sum = acc_sum + AccHalf;

   always_comb begin
      world.world_x = sat_pos(SumW'(rs_ff[0]) + SumW'(item_ff.cam_pos_x) - SumW'(offsets.x));
      world.world_y = sat_pos(SumW'(rs_ff[1]) + SumW'(item_ff.cam_pos_y) - SumW'(offsets.y));
      world.world_z = sat_pos(SumW'(rs_ff[2]) + SumW'(item_ff.cam_pos_z) - SumW'(offsets.z));
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pv_in        = 1'b0;
      prow_in      = prow_ff;
      pcol_in      = pcol_ff;
      item_in      = item_ff;
      qp_in        = qp_ff;
      rm_in        = rm_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rs_in        = rs_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_data_in  = out_data_ff;
      item_ready   = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in  = item_data;
               cnt_in   = '0;
               state_in = ST_QMUL;
            end
         end
         ST_QMUL: begin
            qp_in[cnt_ff] = mul_p[QprodW-1:0];
            if (cnt_ff == QP_WZ) begin
               cnt_in   = '0;
               state_in = ST_RMAT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RMAT: begin
            rm_in[M00] = mat_entry(1'b1, 1'b0, qp_ff[QP_YY], qp_ff[QP_ZZ]);
            rm_in[M01] = mat_entry(1'b0, 1'b1, qp_ff[QP_XY], qp_ff[QP_WZ]);
            rm_in[M02] = mat_entry(1'b0, 1'b0, qp_ff[QP_XZ], qp_ff[QP_WY]);
            rm_in[M10] = mat_entry(1'b0, 1'b0, qp_ff[QP_XY], qp_ff[QP_WZ]);
            rm_in[M11] = mat_entry(1'b1, 1'b0, qp_ff[QP_XX], qp_ff[QP_ZZ]);
            rm_in[M12] = mat_entry(1'b0, 1'b1, qp_ff[QP_YZ], qp_ff[QP_WX]);
            rm_in[M20] = mat_entry(1'b0, 1'b1, qp_ff[QP_XZ], qp_ff[QP_WY]);
            rm_in[M21] = mat_entry(1'b0, 1'b0, qp_ff[QP_YZ], qp_ff[QP_WX]);
            rm_in[M22] = mat_entry(1'b1, 1'b0, qp_ff[QP_XX], qp_ff[QP_YY]);
            cnt_in   = '0;
            row_in   = '0;
            col_in   = BODY_FWD;
            state_in = ST_VMUL;
         end
         ST_VMUL: begin
            if (cnt_ff < NumEnt) begin
               prod_in = mul_p;
               pv_in   = 1'b1;
               prow_in = row_ff;
               pcol_in = col_ff;
               cnt_in  = cnt_ff + 1'b1;
               if (col_ff == BODY_UP) begin
                  col_in = BODY_FWD;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            if (pv_ff) begin
               acc_in = acc_sum;
               if (pcol_ff == BODY_UP) begin
                  rs_in[prow_ff] = round_sum[AccW-1:RowShift];
                  if (prow_ff == ROW_LAST) begin
                     state_in = ST_FIN;
                  end
               end
            end
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_data_in  = world;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      prow_ff     <= prow_in;
      pcol_ff     <= pcol_in;
      item_ff     <= item_in;
      qp_ff       <= qp_in;
      rm_ff       <= rm_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rs_ff       <= rs_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) pv_ff |-> (state_ff == ST_VMUL))
      else $error("Product in flight outside the transform phase.");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> rsp_ch.valid)
      else $error("Response word dropped while the sink stalled.");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> $stable(rsp_ch.data))
      else $error("Response word changed while the sink stalled.");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/camera_object_to_world_transform_top.sv =====
// Top level of the camera object to world transform: front end, queue, back end, offset registers.
// Each word occupies the back end through these steps in order: it is taken from the queue, the
// quaternion products are formed, the rotation matrix is built, the transform products are formed
// and accumulated, and the output is loaded. The back end takes a new word only once the last one
// is done; the queue absorbs QUEUE_DEPTH waiting requests.
// Synchronous active-high reset clears the held object position and restores offset defaults.
`timescale 1ns / 1ps
`default_nettype none

module camera_object_to_world_transform_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   cowt_stream_if.sink                       req_ch,
   cowt_stream_if.source                     rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [cowt_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [cowt_pkg::PosW-1:0]         csr_wdata
);
   import cowt_pkg::*;

   vec_type offset_ff;
   vec_type offset_in;
   logic    push_valid;
   req_type push_data;
   logic    queue_full;
   logic    queue_empty;
   req_type pop_data;
   logic    back_ready;
   logic    pop;

   always_comb begin
      offset_in = offset_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_X: offset_in.x = csr_wdata;
            CSR_OFFSET_Y: offset_in.y = csr_wdata;
            CSR_OFFSET_Z: offset_in.z = csr_wdata;
            default: offset_in = offset_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   cowt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   cowt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   assign pop = !queue_empty && back_ready;

   cowt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!queue_empty),
      .item_data  (pop_data),
      .item_ready (back_ready),
      .offsets    (offset_ff),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the camera object to world transform top level.
`timescale 1ns / 1ps

module testbench;
   import cowt_pkg::*;

   localparam logic [CsrIndexW-1:0] CSR_SPARE = 2'd3;
   localparam pos_type PosMax = 32'sh7FFFFFFF;
   localparam pos_type PosMin = 32'sh80000000;
   localparam pos_type Metre = 32'sd65536;
   localparam quat_type QuatOne = 16'sd16384;
   localparam quat_type QuatDiag = 16'sd11585;
   localparam longint MatOne = 64'sd268435456;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CsrIndexW-1:0] csr_index;
   logic [PosW-1:0] csr_wdata;

   cowt_stream_if #(.payload_type(req_type)) req_ch ();
   cowt_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   camera_object_to_world_transform_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vec_type offsets = OFFSET_RESET;
   vec_type held_obj = '{x: 32'sd0, y: 32'sd0, z: 32'sd0};
   rsp_type pending_world[$];
   bit quiet = 1'b0;
   int mismatches = 0;
   int words_sent = 0;
   int blind_words = 0;
   int saturated_parts = 0;
   int offset_writes = 0;

   always #5 clock = ~clock;

   function automatic longint round_down(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // Substitutes the held object position on no detection, rotates the remapped object position by the
   // unnormalized quaternion matrix, then adds the camera position, takes off the offsets and saturates.
   function automatic rsp_type predict_world(input req_type word);
      longint qw, qx, qy, qz;
      longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
      longint mat[9];
      longint body[3], cam[3], off[3];
      longint acc, sum;
      pos_type world[3];
      vec_type obj;
      obj = '{x: word.obj_cam_x, y: word.obj_cam_y, z: word.obj_cam_z};
      if (obj.z == 0) obj = held_obj;
      if (obj.z != 0) held_obj = obj;
      qw = $signed(word.quat_w);
      qx = $signed(word.quat_x);
      qy = $signed(word.quat_y);
      qz = $signed(word.quat_z);
      xx = qx * qx; yy = qy * qy; zz = qz * qz;
      xy = qx * qy; xz = qx * qz; yz = qy * qz;
      wx = qw * qx; wy = qw * qy; wz = qw * qz;
      mat[0] = MatOne - 2 * (yy + zz);
      mat[1] = 2 * (xy - wz);
      mat[2] = 2 * (xz + wy);
      mat[3] = 2 * (xy + wz);
      mat[4] = MatOne - 2 * (xx + zz);
      mat[5] = 2 * (yz - wx);
      mat[6] = 2 * (xz - wy);
      mat[7] = 2 * (yz + wx);
      mat[8] = MatOne - 2 * (xx + yy);
      body[0] = longint'($signed(obj.z));
      body[1] = -longint'($signed(obj.x));
      body[2] = -longint'($signed(obj.y));
      cam[0] = $signed(word.cam_pos_x);
      cam[1] = $signed(word.cam_pos_y);
      cam[2] = $signed(word.cam_pos_z);
      off[0] = $signed(offsets.x);
      off[1] = $signed(offsets.y);
      off[2] = $signed(offsets.z);
      for (int i = 0; i < 3; i++) begin
         acc = round_down(mat[3*i], MatShift) * body[0]
             + round_down(mat[3*i+1], MatShift) * body[1]
             + round_down(mat[3*i+2], MatShift) * body[2];
         sum = round_down(acc, RowShift) + cam[i] - off[i];
         if (sum > 64'sd2147483647) begin
            world[i] = PosMax;
            saturated_parts++;
         end else if (sum < -64'sd2147483648) begin
            world[i] = PosMin;
            saturated_parts++;
         end else begin
            world[i] = sum[31:0];
         end
      end
      return '{world_x: world[0], world_y: world[1], world_z: world[2]};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic compare_field(input string tag, input pos_type want, input pos_type got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, tag, want, got);
         mismatches++;
      end
   endtask

   task automatic check_world(input rsp_type got);
      rsp_type want;
      if (pending_world.size() == 0) begin
         $display("%0t: world word arrived with none expected, actual %0d %0d %0d",
                  $time, got.world_x, got.world_y, got.world_z);
         mismatches++;
      end else begin
         want = pending_world.pop_front();
         compare_field("world_x", want.world_x, got.world_x);
         compare_field("world_y", want.world_y, got.world_y);
         compare_field("world_z", want.world_z, got.world_z);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_world(rsp_ch.data);
   end

   initial begin
      int burst;
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         burst = ($urandom_range(0, 9) == 0) ? 50 : $urandom_range(1, 12);
         repeat (burst) @(posedge clock);
         gap = quiet ? 0 : pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   task automatic send_word(input req_type word);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (word.obj_cam_z == 0) blind_words++;
      pending_world.push_back(predict_world(word));
      words_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_world.size() != 0) @(posedge clock);
   endtask

   task automatic write_offset(input logic [CsrIndexW-1:0] idx, input pos_type value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_OFFSET_X: offsets.x = value;
         CSR_OFFSET_Y: offsets.y = value;
         CSR_OFFSET_Z: offsets.z = value;
         default: ;
      endcase
      offset_writes++;
      @(posedge clock);
   endtask

   function automatic req_type make_word(input pos_type px, input pos_type py,
                                         input pos_type pz, input quat_type qw,
                                         input quat_type qx, input quat_type qy,
                                         input quat_type qz, input pos_type ox,
                                         input pos_type oy, input pos_type oz);
      return '{cam_pos_x: px, cam_pos_y: py, cam_pos_z: pz, quat_w: qw, quat_x: qx,
               quat_y: qy, quat_z: qz, obj_cam_x: ox, obj_cam_y: oy, obj_cam_z: oz};
   endfunction

   function automatic pos_type random_position();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            case ($urandom_range(0, 4))
               0: return PosMax;
               1: return PosMin;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1, 2: return $urandom;
         default: return $urandom_range(0, 32'hFFFFFF) - 32'd8388608;
      endcase
   endfunction

   function automatic quat_type random_quat_part();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return quat_type'($urandom_range(0, 32768) - 16384);
      if (r < 8) begin
         case ($urandom_range(0, 4))
            0: return 16'sd0;
            1: return QuatDiag;
            2: return -QuatDiag;
            3: return QuatOne;
            default: return -QuatOne;
         endcase
      end
      return quat_type'($urandom);
   endfunction

   function automatic req_type random_word();
      req_type word;
      word = make_word(random_position(), random_position(), random_position(),
                       random_quat_part(), random_quat_part(), random_quat_part(),
                       random_quat_part(), random_position(), random_position(),
                       random_position());
      if ($urandom_range(0, 99) < 15) word.obj_cam_z = 32'sd0;
      return word;
   endfunction

   function automatic pos_type random_offset();
      case ($urandom_range(0, 5))
         0: return PosMax;
         1: return PosMin;
         2: return 32'sd0;
         3: return $urandom;
         default: return $urandom_range(0, 32'h3FFFF) - 32'd131072;
      endcase
   endfunction

   // Reset offsets, no-detection handling, quaternion corner values and saturation.
   task automatic test_directed();
      send_word(make_word(0, 0, 0, QuatOne, 0, 0, 0, 123, 456, 0));
      send_word(make_word(10 * Metre, 20 * Metre, 30 * Metre, QuatOne, 0, 0, 0,
                          Metre, 2 * Metre, 3 * Metre));
      send_word(make_word(Metre, Metre, Metre, QuatOne, 0, 0, 0, 777, -777, 0));
      send_word(make_word(0, 0, 0, QuatDiag, 0, 0, QuatDiag, Metre, -Metre, 2 * Metre));
      send_word(make_word(Metre, 0, -Metre, 0, 0, 0, 0, Metre, Metre, Metre));
      send_word(make_word(0, 0, 0, QuatOne, QuatOne, QuatOne, QuatOne,
                          Metre, 2 * Metre, 3 * Metre));
      send_word(make_word(0, 0, 0, -QuatOne, -QuatOne, -QuatOne, -QuatOne,
                          -Metre, Metre, 5 * Metre));
      send_word(make_word(0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                          Metre, Metre, Metre));
      send_word(make_word(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                          Metre, Metre, Metre));
      send_word(make_word(Metre, Metre, Metre, 16'sh8000, 16'sh7FFF, 0, 16'sh8000,
                          3 * Metre, -2 * Metre, Metre));
      send_word(make_word(PosMax, PosMax, PosMax, QuatOne, 0, 0, 0, 0, 0, PosMax));
      send_word(make_word(PosMin, PosMin, PosMin, QuatOne, 0, 0, 0, 0, 0, PosMin));
      send_word(make_word(0, 0, 0, QuatOne, 0, 0, 0, PosMin, PosMax, 1));
      send_word(make_word(PosMax, PosMin, 0, 0, QuatOne, 0, 0, PosMax, PosMax, PosMax));
      send_word(make_word(-Metre, -Metre, -Metre, QuatOne, 0, 0, 0, 5, 6, -1));
      send_word(make_word(0, 0, 0, QuatDiag, QuatDiag, 0, 0, PosMax, PosMin, 0));
      send_word(make_word(-1, -1, -1, 0, 0, QuatOne, 0, Metre, -Metre, 4 * Metre));
      send_word(make_word(1, 2, 3, 0, 0, 0, -QuatOne, $urandom, $urandom, $urandom | 1));
      wait_drained();
   endtask

   // Every register at its extremes, plus a write to the unused index.
   task automatic test_offset_extremes();
      pos_type settings[4][3];
      settings = '{'{PosMin, PosMin, PosMin}, '{PosMax, PosMax, PosMax}, '{0, 0, 0},
                   '{-1, 1, $urandom}};
      for (int s = 0; s < 4; s++) begin
         write_offset(CSR_OFFSET_X, settings[s][0]);
         write_offset(CSR_OFFSET_Y, settings[s][1]);
         write_offset(CSR_OFFSET_Z, settings[s][2]);
         if (s == 3) write_offset(CSR_SPARE, $urandom);
         send_word(make_word(0, 0, 0, QuatOne, 0, 0, 0, Metre, Metre, Metre));
         send_word(make_word(PosMax, PosMin, PosMax, QuatOne, 0, 0, 0, 0, 0, 1));
         send_word(random_word());
         wait_drained();
      end
   endtask

   // Long random traffic; the first round runs without any idling on either side.
   task automatic test_random_traffic();
      for (int round = 0; round < 5; round++) begin
         quiet = (round == 0);
         wait_drained();
         write_offset(CSR_OFFSET_X, random_offset());
         write_offset(CSR_OFFSET_Y, random_offset());
         write_offset(CSR_OFFSET_Z, random_offset());
         if ($urandom_range(0, 2) == 0) write_offset(CSR_SPARE, $urandom);
         repeat (200) send_word(random_word());
      end
      quiet = 1'b0;
      wait_drained();
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_OFFSET_X;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_offset_extremes();
      test_random_traffic();
      repeat (60) @(posedge clock);
      $display("Sent %0d words, %0d of them without detection, and made %0d offset writes.",
               words_sent, blind_words, offset_writes);
      $display("World components that saturated: %0d.", saturated_parts);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d words still expected.", pending_world.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
